[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Each one samples on the rising edge of
// clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define CHK_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/ssoe_pkg.sv]
// ----------------------------------------------------------------------------
// Small set operation engine package
// Sizes, widths and the action, operation and status codes of the engine.
// ----------------------------------------------------------------------------
package ssoe_pkg;

  // Capacity of each set and the limit on results per compute.
  localparam int SET_CAPACITY = 16;
  localparam int MAX_OUT      = 32;

  // Element and index widths.
  localparam int ELEM_W = 32;
  localparam int IDX_W  = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam int CNT_W  = $clog2(SET_CAPACITY + 1);
  localparam int OUT_W  = $clog2(MAX_OUT + 1);

  // Stream word widths.
  localparam int ACT_W    = 3;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 2;
  localparam int IN_DW    = 32;
  localparam int OUT_DW   = 40;
  localparam int OUT_PADW = OUT_DW - ELEM_W - 1 - STAT_W;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_INS_A   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_B   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 3'd4;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_UNION   = 3'd0;
  localparam logic [OP_W-1:0] OP_INTER   = 3'd1;
  localparam logic [OP_W-1:0] OP_DIFF    = 3'd2;
  localparam logic [OP_W-1:0] OP_SYMDIFF = 3'd3;
  localparam logic [OP_W-1:0] OP_SUBSET  = 3'd4;

  // Insert status codes.
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Sequencer states.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_NEXT  = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_TAKE  = 7'b0010000,
    S_FINAL = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

endpackage

[src/small_set_operation_engine_top.sv]
// ----------------------------------------------------------------------------
// Small set operation engine
// Two small sets of signed 32-bit elements held in synchronous memories, with
// insert, clear, membership query and set operations streamed out word by word.
//
//   Channel   Dir  Handshake          Payload
//   s_*       in   s_tvalid/s_tready  tuser action, tdata element_value
//   m_*       out  m_tvalid/m_tready  tdata element/flag/status, tuser empty, tlast
//   cfg_*     in   cfg_valid/cfg_ready cfg_data operation
//
// Each set memory has one read port, so a scan compares one stored element per
// cycle. A compute makes one pass over its outer set; union and symmetric
// difference make two passes. Reset clears the counts and the operation
// register; the element memories are not cleared. Only one word is in work at
// a time; a stalled output holds the sequencer, and a new input word is taken
// once the last result is registered.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module small_set_operation_engine_top (
  input  logic                         clk,
  input  logic                         rst,
  // Input word.
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ssoe_pkg::IN_DW-1:0]   s_tdata,   // [31:0] element_value
  input  logic [ssoe_pkg::ACT_W-1:0]   s_tuser,   // [2:0] action
  // Result word.
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ssoe_pkg::OUT_DW-1:0]  m_tdata,   // [31:0] result_element,
                                                  // [32] member_flag,
                                                  // [34:33] status, zero above
  output logic                         m_tuser,   // [0] empty_result
  output logic                         m_tlast,
  // Operation register write.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ssoe_pkg::OP_W-1:0]    cfg_data
);
  import ssoe_pkg::*;

  // Element memories.
  logic [ELEM_W-1:0] mem_a [SET_CAPACITY];
  logic [ELEM_W-1:0] mem_b [SET_CAPACITY];
  logic [ELEM_W-1:0] rd_a;
  logic [ELEM_W-1:0] rd_b;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic              we_a;
  logic              we_b;

  // Held input element for the memory write.
  logic [ELEM_W-1:0] s_tdata_hold;

  // Control and working registers.
  state_t            state;
  state_t            state_next;
  logic [OP_W-1:0]   operation;
  logic [CNT_W-1:0]  size_a;
  logic [CNT_W-1:0]  size_b;
  logic [ACT_W-1:0]  act;
  logic              phase;
  logic              inner_sel;
  logic [CNT_W-1:0]  i_cnt;
  logic [CNT_W-1:0]  j_cnt;
  logic [ELEM_W-1:0] key;
  logic              found;
  logic              cmp_pend;
  logic              subset_ok;
  logic              hold_vld;
  logic [ELEM_W-1:0] hold_elem;
  logic [OUT_W-1:0]  out_cnt;

  // Output register.
  logic [ELEM_W-1:0] out_elem;
  logic              out_member;
  logic [STAT_W-1:0] out_status;
  logic              out_empty;

  // Derived control.
  logic [ELEM_W-1:0] rd_outer;
  logic [ELEM_W-1:0] rd_inner;
  logic [CNT_W-1:0]  n_outer;
  logic [CNT_W-1:0]  n_inner;
  logic [CNT_W-1:0]  tgt_size;
  logic              scan_issue;
  logic              scan_end;
  logic              out_free;
  logic              take;
  logic              take_now;
  logic              push_held;
  logic [STAT_W-1:0] ins_status;

  // Load strobe and fields for the output register.
  logic              out_load;
  logic [ELEM_W-1:0] ld_elem;
  logic              ld_member;
  logic [STAT_W-1:0] ld_status;
  logic              ld_empty;
  logic              ld_last;

  // Configuration is always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation <= OP_UNION;
    end else if (cfg_valid) begin
      operation <= cfg_data;
    end
  end

  // One shared read address: the outer element while fetching, the scan index
  // while scanning. Writes only happen in the final step of an insert, when no
  // read is pending, so no forwarding is needed.
  assign rd_addr = (state == S_SCAN) ? j_cnt[IDX_W-1:0] : i_cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wr_addr] <= s_tdata_hold;
    end
    rd_a <= mem_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wr_addr] <= s_tdata_hold;
    end
    rd_b <= mem_b[rd_addr];
  end

  // Selection between the two sets.
  assign rd_outer = phase ? rd_b : rd_a;
  assign rd_inner = inner_sel ? rd_b : rd_a;
  assign n_outer  = phase ? size_b : size_a;
  assign n_inner  = inner_sel ? size_b : size_a;
  assign tgt_size = (act == ACT_INS_B) ? size_b : size_a;
  assign wr_addr  = tgt_size[IDX_W-1:0];

  // Scan progress.
  assign scan_issue = (j_cnt < n_inner);
  assign scan_end   = !scan_issue && !cmp_pend;
  assign out_free   = !m_tvalid || m_tready;

  // Which outer elements go into the result set.
  always_comb begin
    if (phase) begin
      take = !found;
    end else begin
      case (operation) inside
        OP_UNION:                take = 1'b1;
        OP_INTER:                take = found;
        OP_DIFF, OP_SYMDIFF:     take = !found;
        default:                 take = 1'b0;
      endcase
    end
  end

  assign take_now  = take && (out_cnt < OUT_W'(MAX_OUT));
  assign push_held = take_now && hold_vld;

  // Insert outcome: a duplicate is reported before a full set.
  always_comb begin
    if (found) begin
      ins_status = ST_DUP;
    end else if (tgt_size >= CNT_W'(SET_CAPACITY)) begin
      ins_status = ST_FULL;
    end else begin
      ins_status = ST_OK;
    end
  end

  assign s_tdata_hold = key;

  // Sequencer and output register loading.
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    ld_elem    = '0;
    ld_member  = 1'b0;
    ld_status  = ST_OK;
    ld_empty   = 1'b0;
    ld_last    = 1'b0;
    we_a       = 1'b0;
    we_b       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          unique case (s_tuser) inside
            ACT_INS_A, ACT_INS_B, ACT_QUERY: state_next = S_SCAN;
            ACT_CLEAR:                       state_next = S_DONE;
            ACT_COMPUTE: begin
              state_next = (operation > OP_SUBSET) ? S_FINAL : S_NEXT;
            end
            default:                         state_next = S_IDLE;
          endcase
        end
      end
      S_NEXT: begin
        if (i_cnt < n_outer) begin
          state_next = S_LOAD;
        end else if (!(!phase && (operation == OP_UNION || operation == OP_SYMDIFF))) begin
          state_next = S_FINAL;
        end
      end
      S_LOAD: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = (act == ACT_COMPUTE) ? S_TAKE : S_DONE;
        end
      end
      S_TAKE: begin
        if (!push_held || out_free) begin
          out_load   = push_held;
          ld_elem    = hold_elem;
          state_next = S_NEXT;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_last  = 1'b1;
          if (operation == OP_SUBSET) begin
            ld_member = subset_ok;
          end else if (hold_vld) begin
            ld_elem = hold_elem;
          end else begin
            ld_empty = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_last  = 1'b1;
          case (act)
            ACT_INS_A: begin
              ld_status = ins_status;
              we_a      = (ins_status == ST_OK);
            end
            ACT_INS_B: begin
              ld_status = ins_status;
              we_b      = (ins_status == ST_OK);
            end
            ACT_QUERY: ld_member = found;
            default:   ld_member = 1'b0;
          endcase
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign s_tready = (state == S_IDLE);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      size_a   <= '0;
      size_b   <= '0;
      hold_vld <= 1'b0;
      cmp_pend <= 1'b0;
      out_cnt  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act       <= s_tuser;
            key       <= s_tdata;
            j_cnt     <= '0;
            found     <= 1'b0;
            cmp_pend  <= 1'b0;
            inner_sel <= (s_tuser == ACT_INS_B);
            phase     <= 1'b0;
            i_cnt     <= '0;
            subset_ok <= 1'b1;
            hold_vld  <= 1'b0;
            out_cnt   <= '0;
          end
        end
        S_NEXT: begin
          inner_sel <= !phase;
          if (!(i_cnt < n_outer) && !phase &&
              (operation == OP_UNION || operation == OP_SYMDIFF)) begin
            phase <= 1'b1;
            i_cnt <= '0;
          end
        end
        S_LOAD: begin
          key      <= rd_outer;
          j_cnt    <= '0;
          found    <= 1'b0;
          cmp_pend <= 1'b0;
        end
        S_SCAN: begin
          // Issue one read a cycle and compare the word read the cycle before.
          cmp_pend <= scan_issue;
          if (scan_issue) begin
            j_cnt <= j_cnt + 1'b1;
          end
          if (cmp_pend && (rd_inner == key)) begin
            found <= 1'b1;
          end
        end
        S_TAKE: begin
          if (!push_held || out_free) begin
            if (take_now) begin
              hold_elem <= key;
              hold_vld  <= 1'b1;
              out_cnt   <= out_cnt + 1'b1;
            end
            if (operation == OP_SUBSET && !found) begin
              subset_ok <= 1'b0;
            end
            i_cnt <= i_cnt + 1'b1;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            hold_vld <= 1'b0;
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (we_a) begin
              size_a <= size_a + 1'b1;
            end
            if (we_b) begin
              size_b <= size_b + 1'b1;
            end
            if (act == ACT_CLEAR) begin
              size_a <= '0;
              size_b <= '0;
            end
          end
        end
        default: begin
          cmp_pend <= 1'b0;
        end
      endcase
    end
  end

  // Output register: one result word waits here for the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_elem   <= ld_elem;
      out_member <= ld_member;
      out_status <= ld_status;
      out_empty  <= ld_empty;
      m_tlast    <= ld_last;
    end
  end

  assign m_tdata = {{OUT_PADW{1'b0}}, out_status, out_member, out_elem};
  assign m_tuser = out_empty;

  // Checks.
  `CHK_ALWAYS(a_size_a_bound, size_a <= CNT_W'(SET_CAPACITY), "set A count beyond capacity")
  `CHK_ALWAYS(a_size_b_bound, size_b <= CNT_W'(SET_CAPACITY), "set B count beyond capacity")
  `CHK_IMPLY(a_write_room, we_a || we_b, tgt_size < CNT_W'(SET_CAPACITY), "write into full set")
  `CHK_IMPLY(a_idle_clean, s_tready, !hold_vld, "held result left behind at idle")
  `CHK_NEXT(a_scan_cmp, (state == S_SCAN) && scan_issue, cmp_pend, "read without compare")

endmodule

[tb/tb_small_set_operation_engine_top.sv]
// ----------------------------------------------------------------------------
// Small set operation engine testbench
// Drives insert, clear, query and compute words into the engine and checks
// every result word against a cycle-free predictor of the two sets. A short
// directed pass covers the value extremes, every action and operation and the
// corner cases; random phases then build up sets of many shapes under several
// operation settings and several patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_small_set_operation_engine_top;
  import ssoe_pkg::*;

  // Codes the package leaves unnamed: the reserved actions and operations.
  localparam logic [ACT_W-1:0] ACT_RSVD_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD_HI = 3'd7;
  localparam logic [OP_W-1:0]  OP_RSVD     = 3'd7;

  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 24;
  localparam int POOL_SIZE    = 40;
  localparam int SETTLE_WAIT  = 700;    // idle wait before an operation write and before the verdict
  localparam int HOLD_CYCLES  = 500;    // long receiver hold-off
  localparam int QUIET_LIMIT  = 20000;  // cycles with no handshake at all

  // Expected contents of one result word.
  typedef struct packed {
    logic [ELEM_W-1:0] elem;
    logic              flag;
    logic [STAT_W-1:0] status;
    logic              empty;
    logic              last;
  } set_result_t;

  // Scoreboard: keeps its own copy of both sets and the operation register,
  // and queues the result words each accepted input word should produce.
  class set_scoreboard;
    bit [ELEM_W-1:0] a_elems[SET_CAPACITY];
    bit [ELEM_W-1:0] b_elems[SET_CAPACITY];
    int unsigned     a_size;
    int unsigned     b_size;
    logic [OP_W-1:0] op_sel;
    set_result_t     expected_q[$];
    int errors, n_inputs, n_results, n_computes, n_dup, n_full, n_cfg;

    function new();
      a_size = 0;
      b_size = 0;
      op_sel = OP_UNION;
      errors = 0;
      n_inputs = 0;
      n_results = 0;
      n_computes = 0;
      n_dup = 0;
      n_full = 0;
      n_cfg = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit holds(bit [ELEM_W-1:0] elems[SET_CAPACITY], int unsigned n,
                       bit [ELEM_W-1:0] v);
      for (int unsigned i = 0; i < n; i++) begin
        if (elems[i] == v) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void push_word(bit [ELEM_W-1:0] elem, bit flag, bit [STAT_W-1:0] status,
                            bit empty, bit last);
      set_result_t w;
      w.elem = elem;
      w.flag = flag;
      w.status = status;
      w.empty = empty;
      w.last = last;
      expected_q.push_back(w);
    endfunction

    // Duplicate check comes before the fullness check.
    function bit [STAT_W-1:0] insert_elem(bit to_b, bit [ELEM_W-1:0] v);
      if (to_b) begin
        if (holds(b_elems, b_size, v)) begin
          n_dup++;
          return ST_DUP;
        end
        if (b_size >= SET_CAPACITY) begin
          n_full++;
          return ST_FULL;
        end
        b_elems[b_size] = v;
        b_size++;
      end else begin
        if (holds(a_elems, a_size, v)) begin
          n_dup++;
          return ST_DUP;
        end
        if (a_size >= SET_CAPACITY) begin
          n_full++;
          return ST_FULL;
        end
        a_elems[a_size] = v;
        a_size++;
      end
      return ST_OK;
    endfunction

    function void note_input(logic [ACT_W-1:0] action, logic [ELEM_W-1:0] value);
      bit [ELEM_W-1:0] found[$];
      bit subset_ok;
      bit in_b;
      int n;
      n_inputs++;
      case (action)
        ACT_INS_A: push_word('0, 1'b0, insert_elem(1'b0, value), 1'b0, 1'b1);
        ACT_INS_B: push_word('0, 1'b0, insert_elem(1'b1, value), 1'b0, 1'b1);
        ACT_CLEAR: begin
          a_size = 0;
          b_size = 0;
          push_word('0, 1'b0, ST_OK, 1'b0, 1'b1);
        end
        ACT_QUERY: push_word('0, holds(a_elems, a_size, value), ST_OK, 1'b0, 1'b1);
        ACT_COMPUTE: begin
          n_computes++;
          if (op_sel == OP_SUBSET) begin
            // An empty A lies within any B.
            subset_ok = 1'b1;
            for (int unsigned i = 0; i < a_size; i++) begin
              if (!holds(b_elems, b_size, a_elems[i])) subset_ok = 1'b0;
            end
            push_word('0, subset_ok, ST_OK, 1'b0, 1'b1);
          end else begin
            // Reserved operation codes leave the list empty.
            if (op_sel <= OP_SYMDIFF) begin
              for (int unsigned i = 0; i < a_size; i++) begin
                in_b = holds(b_elems, b_size, a_elems[i]);
                if (op_sel == OP_UNION || (op_sel == OP_INTER ? in_b : !in_b))
                  found.push_back(a_elems[i]);
              end
              if (op_sel == OP_UNION || op_sel == OP_SYMDIFF) begin
                for (int unsigned i = 0; i < b_size; i++) begin
                  if (!holds(a_elems, a_size, b_elems[i])) found.push_back(b_elems[i]);
                end
              end
            end
            if (found.size() == 0) begin
              push_word('0, 1'b0, ST_OK, 1'b1, 1'b1);
            end else begin
              // The list is cut off at the result limit.
              n = (found.size() < MAX_OUT) ? found.size() : MAX_OUT;
              for (int i = 0; i < n; i++)
                push_word(found[i], 1'b0, ST_OK, 1'b0, i == n - 1);
            end
          end
        end
        default: ;  // reserved actions are ignored
      endcase
    endfunction

    function void mismatch(string field, logic [ELEM_W-1:0] want, logic [ELEM_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_result(logic [OUT_DW-1:0] data, logic user, logic tlast);
      set_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected: expected none, actual %h/%b/%b",
                 $time, data, user, tlast);
        return;
      end
      want = expected_q.pop_front();
      n_results++;
      if (data[ELEM_W-1:0] !== want.elem) mismatch("result_element", want.elem,
                                                   data[ELEM_W-1:0]);
      if (data[ELEM_W] !== want.flag) mismatch("member_flag", want.flag, data[ELEM_W]);
      if (data[ELEM_W+STAT_W:ELEM_W+1] !== want.status)
        mismatch("status", want.status, data[ELEM_W+STAT_W:ELEM_W+1]);
      if (data[OUT_DW-1 -: OUT_PADW] !== '0) mismatch("tdata padding", '0,
                                                      data[OUT_DW-1 -: OUT_PADW]);
      if (user !== want.empty) mismatch("empty_result", want.empty, user);
      if (tlast !== want.last) mismatch("last", want.last, tlast);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_DW-1:0]    s_tdata = '0;
  logic [ACT_W-1:0]    s_tuser = ACT_INS_A;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_DW-1:0]   m_tdata;
  logic                m_tuser;
  logic                m_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [OP_W-1:0]     cfg_data = OP_UNION;

  set_scoreboard       sb;
  int                  sender_idle_pct = 0;
  int                  recv_stall_pct = 0;
  logic                pressure_go = 1'b0;
  int                  hold_count = 0;
  int                  quiet_cycles = 0;
  bit [ELEM_W-1:0]     value_pool[POOL_SIZE];

  small_set_operation_engine_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Clock generator.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: check accepted words, then pick the next ready level.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
      if (pressure_go && hold_count < HOLD_CYCLES) begin
        m_tready <= 1'b0;
        hold_count <= hold_count + 1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_small_set_operation_engine_top: FAIL");
      $finish;
    end
  end

  // Offer one input word after a random gap and wait for it to be taken.
  task automatic send_word(logic [ACT_W-1:0] action, logic [ELEM_W-1:0] value);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= action;
    s_tdata <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(action, value);
  endtask

  // The operation register is written only once the engine has gone idle.
  task automatic write_operation(logic [OP_W-1:0] op);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= op;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.op_sel = op;
    sb.n_cfg++;
  endtask

  initial begin : stimulus
    logic [OP_W-1:0]  first_ops[5];
    logic [OP_W-1:0]  op;
    logic [ACT_W-1:0] act;
    logic [ELEM_W-1:0] val;
    int pool_n, clear_pct, counted, r;

    sb = new();
    first_ops = '{OP_SUBSET, OP_INTER, OP_DIFF, OP_SYMDIFF, OP_UNION};
    // Pool with the signed extremes, zero and minus one, so that random
    // inserts collide and sets overlap.
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    value_pool[4] = 32'h0000_0001;
    for (int i = 5; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, operation at its reset value of union.
    send_word(ACT_COMPUTE, 32'h0);            // union of two empty sets
    send_word(ACT_QUERY, 32'h0);              // query on an empty A
    send_word(ACT_INS_A, 32'h8000_0000);
    send_word(ACT_INS_A, 32'h7fff_ffff);
    send_word(ACT_INS_A, 32'h0000_0000);
    send_word(ACT_INS_A, 32'hffff_ffff);
    send_word(ACT_INS_A, 32'h8000_0000);      // duplicate
    send_word(ACT_INS_B, 32'h7fff_ffff);
    send_word(ACT_INS_B, 32'h0000_0005);
    send_word(ACT_INS_B, 32'hffff_ffff);
    send_word(ACT_INS_B, 32'h0000_0005);      // duplicate
    send_word(ACT_QUERY, 32'h8000_0000);
    send_word(ACT_QUERY, 32'h0000_0005);
    send_word(ACT_COMPUTE, 32'hdead_beef);
    send_word(ACT_RSVD_LO, 32'h0000_0011);    // reserved actions do nothing
    send_word(ACT_RSVD_LO + 3'd1, 32'h0000_0022);
    send_word(ACT_RSVD_HI, 32'h0000_0033);
    foreach (first_ops[i]) begin
      write_operation(first_ops[i]);
      send_word(ACT_COMPUTE, 32'h0);
    end
    write_operation(OP_RSVD);                 // reserved operation: empty result
    send_word(ACT_COMPUTE, 32'h0);
    write_operation(OP_SUBSET);
    send_word(ACT_CLEAR, 32'hffff_ffff);
    send_word(ACT_COMPUTE, 32'h0);            // empty A lies within empty B

    // Random phases, each with its own operation, idling pattern and pool.
    for (int p = 0; p < NUM_PHASES; p++) begin
      op = (p < 5) ? first_ops[p] : 3'($urandom_range(OP_UNION, OP_SUBSET));
      write_operation(op);
      case (p % 4)
        0: begin sender_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin sender_idle_pct <= 81; recv_stall_pct <= 0;  end
        2: begin sender_idle_pct <= 0;  recv_stall_pct <= 81; end
        default: begin sender_idle_pct <= 22; recv_stall_pct <= 22; end
      endcase
      if (p == 4) pressure_go <= 1'b1;
      pool_n = (p % 3 == 0) ? POOL_SIZE : $urandom_range(4, 24);
      // Sets keep growing across phases unless a clear phase comes along.
      clear_pct = (p % 3 == 1) ? 4 : 0;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < clear_pct)       act = ACT_CLEAR;
        else if (r < 36)         act = ACT_INS_A;
        else if (r < 68)         act = ACT_INS_B;
        else if (r < 80)         act = ACT_QUERY;
        else if (r < 96)         act = ACT_COMPUTE;
        else                     act = 3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
        val = ($urandom_range(0, 99) < 85) ? value_pool[$urandom_range(0, pool_n - 1)]
                                           : $urandom;
        send_word(act, val);
        if (act <= ACT_COMPUTE) counted++;
      end
    end

    // Drain and let any ignored word finish before the verdict.
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    $display("Covered %0d input words with %0d computes over %0d operation writes.",
             sb.n_inputs, sb.n_computes, sb.n_cfg);
    $display("Checked %0d result words; %0d duplicate and %0d full-set inserts refused.",
             sb.n_results, sb.n_dup, sb.n_full);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_small_set_operation_engine_top: PASS");
    end else begin
      $display("%0d mismatches, %0d result words never arrived", sb.errors, sb.pending());
      $display("tb_small_set_operation_engine_top: FAIL");
    end
    $finish;
  end

endmodule
